FILE: src/bpa_pkg.sv
// Buddy page allocator package: sizes, codes, command/status structs, list geometry.
// Used by every allocator module but bpa_ram; depends on nothing.
package bpa_pkg;

	localparam int MinOrder   = 12;
	localparam int MaxOrder   = 20;
	localparam int Levels     = MaxOrder - MinOrder;
	localparam int NumOrders  = Levels + 1;
	localparam int StoreDepth = (2 << Levels) - 1;
	localparam int StoreAw    = $clog2(StoreDepth);
	localparam int IdxW       = Levels;
	localparam int CntW       = Levels + 1;
	localparam int LvlW       = $clog2(NumOrders + 1);
	localparam int AddrW      = 48;
	localparam int BaseW      = 47;
	localparam int LenW       = 32;
	localparam int SizeW      = 32;

	typedef logic [LvlW-1:0]    lvl_t;
	typedef logic [StoreAw-1:0] saddr_t;
	typedef logic [IdxW-1:0]    idx_t;
	typedef logic [CntW-1:0]    cnt_t;

	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_NOFREE = 2'd1,
		ST_BAD    = 2'd2
	} status_t;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_code_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_ALLOC_POP, OP_ALLOC_IDX, OP_SPLIT, OP_SET_RES, OP_EMIT,
		OP_SRCH_INIT, OP_SRCH_RD, OP_SRCH_CMP, OP_SHIFT_INIT, OP_SHIFT_LVL,
		OP_SHIFT_RD, OP_SHIFT_WR, OP_SHIFT_END, OP_FREE_PUSH
	} dp_op_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DEC, S_AIDX, S_SPLIT, S_SRCH, S_CMP, S_CHK,
		S_UNL0, S_UNL, S_SHW, S_FIN, S_OUT
	} state_t;

	typedef struct packed {
		dp_op_t  op;
		status_t st;
	} dp_cmd_t;

	typedef struct packed {
		logic is_alloc;
		logic too_big;
		logic any_free;
		logic free_bad;
		logic need_split;
		logic at_top;
		logic n_zero;
		logic match;
		logic final_full;
		logic at_kfin;
		logic shift_more;
		logic out_busy;
	} dp_sts_t;

	function automatic saddr_t list_start(lvl_t r);
		logic [StoreAw:0] span;
		span = (StoreAw+1)'(2 << Levels);
		return StoreAw'(span - (span >> r));
	endfunction

	function automatic cnt_t list_cap(lvl_t r);
		return CntW'(1) << (LvlW'(Levels) - r);
	endfunction

endpackage

FILE: src/bpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module bpa_ram #(
	parameter int Width = 8,
	parameter int Depth = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: src/bpa_datapath.sv
// Allocator datapath: free list store, list counts, request and result registers.
// Depends on bpa_pkg and bpa_ram; driven by bpa_ctrl through dp_cmd_t.
module bpa_datapath
	import bpa_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             ctl,
	output dp_sts_t             sts,
	input  logic                cmd,
	input  logic [SizeW-1:0]    req_size,
	input  logic [AddrW-1:0]    free_addr,
	input  logic [BaseW-1:0]    base_addr,
	input  logic [LenW-1:0]     region_length,
	input  logic                rebuild,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [AddrW-1:0]    block_addr,
	output logic [1:0]          status
);

	logic             cmd_q;
	lvl_t             ord_q, lvl_q, kfin_q;
	logic [AddrW-1:0] off_q;
	logic             under_q;
	cnt_t             n_q;
	idx_t             idx_q, cur_q;
	idx_t             pos_q [NumOrders];
	cnt_t             cnt_q [NumOrders];
	logic [AddrW-1:0] r_addr_q, block_addr_q;
	status_t          r_stat_q, status_q;
	logic             out_valid_q;

	logic   top_ok, any_free, free_bad;
	lvl_t   top_r, ord_in, fr, lvl_dn;
	idx_t   bud, amask;
	saddr_t start_lvl, raddr, waddr;
	idx_t   rdata, wdata;
	logic   we;

	always_comb begin
		top_ok = |region_length[LenW-1:MinOrder];
		top_r  = '0;
		for (int i = 0; i < Levels; i++) begin
			if (region_length[MinOrder+i]) begin
				top_r = LvlW'(i);
			end
		end
		if (|region_length[LenW-1:MaxOrder]) begin
			top_r = LvlW'(Levels);
		end
	end

	always_comb begin
		ord_in = LvlW'(NumOrders);
		for (int r = Levels; r >= 0; r--) begin
			if ({1'b0, req_size} <= ((SizeW+1)'(1) << (MinOrder + r))) begin
				ord_in = LvlW'(r);
			end
		end
	end

	always_comb begin
		fr       = '0;
		any_free = 1'b0;
		for (int r = Levels; r >= 0; r--) begin
			if (LvlW'(r) >= ord_q && cnt_q[r] != '0) begin
				fr       = LvlW'(r);
				any_free = 1'b1;
			end
		end
	end

	assign lvl_dn    = lvl_q - LvlW'(1);
	assign bud       = cur_q ^ (IdxW'(1) << lvl_q[$clog2(IdxW)-1:0]);
	assign start_lvl = list_start(lvl_q);
	assign amask     = IdxW'((CntW'(1) << ord_q) - CntW'(1));

	assign free_bad = !top_ok || ord_q > top_r || under_q
		|| ((off_q[AddrW-1:MinOrder] >> top_r) != '0)
		|| (off_q[MinOrder-1:0] != '0)
		|| ((off_q[MinOrder+IdxW-1:MinOrder] & amask) != '0);

	always_comb begin
		case (ctl.op)
			OP_ALLOC_POP: raddr = list_start(fr) + StoreAw'(cnt_q[fr] - CntW'(1));
			OP_SRCH_RD:   raddr = start_lvl + StoreAw'(n_q - CntW'(1));
			OP_SHIFT_RD:  raddr = start_lvl + StoreAw'(n_q + CntW'(1));
			default:      raddr = '0;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		if (rebuild) begin
			we    = top_ok;
			waddr = list_start(top_r);
		end else begin
			case (ctl.op)
				OP_SPLIT: begin
					we    = cnt_q[lvl_dn] < list_cap(lvl_dn);
					waddr = list_start(lvl_dn) + StoreAw'(cnt_q[lvl_dn]);
					wdata = idx_q + (IdxW'(1) << lvl_dn[$clog2(IdxW)-1:0]);
				end
				OP_SHIFT_WR: begin
					we    = 1'b1;
					waddr = start_lvl + StoreAw'(n_q);
					wdata = rdata;
				end
				OP_FREE_PUSH: begin
					we    = 1'b1;
					waddr = start_lvl + StoreAw'(cnt_q[lvl_q]);
					wdata = cur_q;
				end
				default: we = 1'b0;
			endcase
		end
	end

	bpa_ram #(.Width(IdxW), .Depth(StoreDepth)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NumOrders; r++) begin
				cnt_q[r] <= '0;
			end
		end else if (rebuild) begin
			for (int r = 0; r < NumOrders; r++) begin
				cnt_q[r] <= '0;
			end
			if (top_ok) begin
				cnt_q[top_r] <= CntW'(1);
			end
		end else begin
			case (ctl.op)
				OP_ALLOC_POP: cnt_q[fr] <= cnt_q[fr] - CntW'(1);
				OP_SPLIT: begin
					if (cnt_q[lvl_dn] < list_cap(lvl_dn)) begin
						cnt_q[lvl_dn] <= cnt_q[lvl_dn] + CntW'(1);
					end
				end
				OP_SHIFT_END: cnt_q[lvl_q] <= cnt_q[lvl_q] - CntW'(1);
				OP_FREE_PUSH: cnt_q[lvl_q] <= cnt_q[lvl_q] + CntW'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_LOAD: begin
				cmd_q   <= cmd;
				ord_q   <= ord_in;
				off_q   <= free_addr - {1'b0, base_addr};
				under_q <= free_addr < {1'b0, base_addr};
			end
			OP_ALLOC_POP: lvl_q <= fr;
			OP_ALLOC_IDX: idx_q <= rdata;
			OP_SPLIT:     lvl_q <= lvl_dn;
			OP_SET_RES: begin
				r_stat_q <= ctl.st;
				if (ctl.st == ST_DONE && cmd_q == CMD_ALLOC) begin
					r_addr_q <= {1'b0, base_addr}
						+ {{(AddrW-IdxW-MinOrder){1'b0}}, idx_q, {MinOrder{1'b0}}};
				end else begin
					r_addr_q <= '0;
				end
			end
			OP_SRCH_INIT: begin
				lvl_q <= ord_q;
				n_q   <= cnt_q[ord_q];
				cur_q <= off_q[MinOrder+IdxW-1:MinOrder];
			end
			OP_SRCH_CMP: begin
				if (rdata == bud) begin
					pos_q[lvl_q] <= IdxW'(n_q - CntW'(1));
					cur_q        <= (bud < cur_q) ? bud : cur_q;
					lvl_q        <= lvl_q + LvlW'(1);
					n_q          <= cnt_q[lvl_q + LvlW'(1)];
				end else begin
					n_q <= n_q - CntW'(1);
				end
			end
			OP_SHIFT_INIT: begin
				kfin_q <= lvl_q;
				lvl_q  <= ord_q;
			end
			OP_SHIFT_LVL: n_q   <= {1'b0, pos_q[lvl_q]};
			OP_SHIFT_WR:  n_q   <= n_q + CntW'(1);
			OP_SHIFT_END: lvl_q <= lvl_q + LvlW'(1);
			OP_EMIT: begin
				block_addr_q <= r_addr_q;
				status_q     <= r_stat_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.op == OP_EMIT) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		sts.is_alloc   = cmd_q == CMD_ALLOC;
		sts.too_big    = ord_q == LvlW'(NumOrders);
		sts.any_free   = any_free;
		sts.free_bad   = free_bad;
		sts.need_split = lvl_q > ord_q;
		sts.at_top     = lvl_q == top_r;
		sts.n_zero     = n_q == '0;
		sts.match      = rdata == bud;
		sts.final_full = cnt_q[lvl_q] >= list_cap(lvl_q);
		sts.at_kfin    = lvl_q == kfin_q;
		sts.shift_more = ({1'b0, n_q} + (CntW+1)'(1)) < {1'b0, cnt_q[lvl_q]};
		sts.out_busy   = out_valid_q & ~out_ready;
	end

	assign out_valid  = out_valid_q;
	assign block_addr = block_addr_q;
	assign status     = status_q;

endmodule

FILE: src/bpa_ctrl.sv
// Allocator controller: sequences allocate, split, buddy search, unlink and result beats.
// Depends on bpa_pkg; drives bpa_datapath through dp_cmd_t.
module bpa_ctrl
	import bpa_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  dp_sts_t sts,
	output dp_cmd_t ctl
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (in_valid) state_d = S_DEC;
			S_DEC: begin
				if (sts.is_alloc) begin
					state_d = (sts.too_big || !sts.any_free) ? S_OUT : S_AIDX;
				end else begin
					state_d = sts.free_bad ? S_OUT : S_SRCH;
				end
			end
			S_AIDX:  state_d = S_SPLIT;
			S_SPLIT: if (!sts.need_split) state_d = S_OUT;
			S_SRCH:  state_d = (sts.at_top || sts.n_zero) ? S_CHK : S_CMP;
			S_CMP:   state_d = S_SRCH;
			S_CHK:   state_d = sts.final_full ? S_OUT : S_UNL0;
			S_UNL0:  state_d = sts.at_kfin ? S_FIN : S_UNL;
			S_UNL:   state_d = sts.shift_more ? S_SHW : S_UNL0;
			S_SHW:   state_d = S_UNL;
			S_FIN:   state_d = S_OUT;
			S_OUT:   if (!sts.out_busy) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctl.op = OP_NONE;
		ctl.st = ST_DONE;
		case (state_q)
			S_IDLE: if (in_valid) ctl.op = OP_LOAD;
			S_DEC: begin
				if (sts.is_alloc) begin
					if (sts.too_big) begin
						ctl.op = OP_SET_RES;
						ctl.st = ST_BAD;
					end else if (!sts.any_free) begin
						ctl.op = OP_SET_RES;
						ctl.st = ST_NOFREE;
					end else begin
						ctl.op = OP_ALLOC_POP;
					end
				end else if (sts.free_bad) begin
					ctl.op = OP_SET_RES;
					ctl.st = ST_BAD;
				end else begin
					ctl.op = OP_SRCH_INIT;
				end
			end
			S_AIDX:  ctl.op = OP_ALLOC_IDX;
			S_SPLIT: ctl.op = sts.need_split ? OP_SPLIT : OP_SET_RES;
			S_SRCH:  if (!(sts.at_top || sts.n_zero)) ctl.op = OP_SRCH_RD;
			S_CMP:   ctl.op = OP_SRCH_CMP;
			S_CHK: begin
				if (sts.final_full) begin
					ctl.op = OP_SET_RES;
					ctl.st = ST_BAD;
				end else begin
					ctl.op = OP_SHIFT_INIT;
				end
			end
			S_UNL0:  ctl.op = sts.at_kfin ? OP_FREE_PUSH : OP_SHIFT_LVL;
			S_UNL:   ctl.op = sts.shift_more ? OP_SHIFT_RD : OP_SHIFT_END;
			S_SHW:   ctl.op = OP_SHIFT_WR;
			S_FIN:   ctl.op = OP_SET_RES;
			S_OUT:   if (!sts.out_busy) ctl.op = OP_EMIT;
			default: ctl.op = OP_NONE;
		endcase
	end

	assign in_ready = state_q == S_IDLE;

	a_accept_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_DEC)
		else $error("accepted beat not decoded");

	a_result_parks: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.op == OP_SET_RES |=> state_q == S_OUT)
		else $error("result set without moving to output");

	a_emit_idles: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.op == OP_EMIT |=> state_q == S_IDLE && !sts.out_busy || state_q == S_IDLE)
		else $error("emit did not return to idle");

endmodule

FILE: src/buddy_page_allocator.sv
// Buddy page allocator top level: APB register file, controller and datapath.
// Depends on bpa_pkg, bpa_ctrl, bpa_datapath (which holds bpa_ram).
//
// Request beats (cmd, req_size, free_addr) enter on in_valid/in_ready; each gives
// one result beat (block_addr, status) on out_valid/out_ready. One request is
// in flight at a time; in_ready is high while the controller is idle.
// An allocate pops a block and splits it down one level at a time; a free runs
// the buddy search, then unlinks each merged buddy by moving the entries above
// it down, and pushes the merged block. A free whose final list is already full
// is rejected. The free list store is one RAM with one read and one write port;
// its registered read data paces the search and unlink loops.
// The result sits in an output register: a stalled receiver holds it, and the
// next request is still taken; it then waits for the register to clear.
// Reset empties every free list and clears base_addr and region_length, so
// there is no region until configured. A write to either register rebuilds the
// lists with one block of the largest power of two fitting the region, capped at MaxOrder.
module buddy_page_allocator
	import bpa_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [63:0]         pwdata,
	output logic [63:0]         prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                cmd,
	input  logic [SizeW-1:0]    req_size,
	input  logic [AddrW-1:0]    free_addr,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [AddrW-1:0]    block_addr,
	output logic [1:0]          status
);

	logic [BaseW-1:0] base_addr_q;
	logic [LenW-1:0]  region_length_q;
	logic             rebuild_q;
	logic             cfg_we;
	dp_cmd_t          ctl;
	dp_sts_t          sts;

	assign cfg_we = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_addr_q     <= '0;
			region_length_q <= '0;
			rebuild_q       <= 1'b0;
		end else begin
			rebuild_q <= cfg_we;
			if (cfg_we) begin
				if (paddr[3]) begin
					region_length_q <= pwdata[LenW-1:0];
				end else begin
					base_addr_q <= pwdata[BaseW-1:0];
				end
			end
		end
	end

	assign prdata = paddr[3] ? {{(64-LenW){1'b0}}, region_length_q}
	                         : {{(64-BaseW){1'b0}}, base_addr_q};

	bpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	bpa_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.sts           (sts),
		.cmd           (cmd),
		.req_size      (req_size),
		.free_addr     (free_addr),
		.base_addr     (base_addr_q),
		.region_length (region_length_q),
		.rebuild       (rebuild_q),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.block_addr    (block_addr),
		.status        (status)
	);

endmodule
